// ===== hdl/svs_pkg.sv =====
`timescale 1ns / 1ps
package svs_pkg;

    localparam int MAX_NZ = 256;
    localparam int CNT_W  = $clog2(MAX_NZ + 1);
    localparam int ADDR_W = (MAX_NZ > 1) ? $clog2(MAX_NZ) : 1;
    localparam int ACC_W  = 48;
    localparam int PROD_W = 34;
    localparam int OPND_W = 17;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] SQ_BIT_INIT = {2'b01, {(ACC_W-2){1'b0}}};

    localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [1:0] OP_COMPUTE     = 2'd2;

    localparam logic [1:0] MODE_DOT  = 2'd0;
    localparam logic [1:0] MODE_SQD  = 2'd1;
    localparam logic [1:0] MODE_DIST = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [15:0]        column_index;
        logic signed [15:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] result_value;
        logic                    saturated;
        logic                    load_error;
    } t_out_item;

    typedef struct packed {
        logic [15:0] idx;
        logic [15:0] val;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_MUL,
        S_ACC,
        S_SQRT,
        S_DONE
    } t_state;

endpackage

// ===== hdl/sparse_vector_similarity_core.sv =====
`timescale 1ns / 1ps
// Sparse vector similarity core. Loads (operation 0 or 1) write one nonzero element into the
// first or second buffer and are taken one per cycle while idle; each buffer holds 256
// elements in strictly ascending column order, and a rejected load only raises load_error.
// A compute (operation 2) merge-walks both buffer memories through their registered read
// port: each merge step that adds a term goes through read, compare, multiply and accumulate,
// while a dot product skips an unmatched column with read and compare only; then come the end
// check and the hand-off to the output register, with mode 2's bit-serial square root between.
// The input is not ready from a compute's transfer until its result has entered the output
// register; loads may continue while that result waits to be taken.
module sparse_vector_similarity_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  svs_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output svs_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_data
);
    import svs_pkg::*;

    t_state r_state, n_state;

    logic [1:0]       r_mode;
    logic [CNT_W-1:0] r_first_count, n_first_count;
    logic [CNT_W-1:0] r_second_count, n_second_count;
    logic [15:0]      r_first_last, n_first_last;
    logic [15:0]      r_second_last, n_second_last;
    logic             r_err, n_err;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic             r_out_valid, n_out_valid;

    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_sat, n_sat;
    logic signed [OPND_W-1:0] r_op_a, n_op_a;
    logic signed [OPND_W-1:0] r_op_b, n_op_b;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [ACC_W-1:0]         r_sq_v, n_sq_v;
    logic [ACC_W-1:0]         r_sq_root, n_sq_root;
    logic [ACC_W-1:0]         r_sq_bit, n_sq_bit;
    t_out_item                r_out_data, n_out_data;

    t_entry mem_first  [MAX_NZ];
    t_entry mem_second [MAX_NZ];
    t_entry r_rd_first, r_rd_second;

    logic   in_fire, wr_first, wr_second, slot_free;
    logic   i_ok, j_ok, loop_cont, idx_eq, idx_lt;
    t_entry wr_entry;
    logic [ACC_W:0]   sum_ext;
    logic [ACC_W-1:0] sq_try;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign slot_free   = !r_out_valid || i_out_ready;

    assign i_ok   = (r_i < r_first_count);
    assign j_ok   = (r_j < r_second_count);
    assign idx_eq = (r_rd_first.idx == r_rd_second.idx);
    assign idx_lt = (r_rd_first.idx < r_rd_second.idx);

    always_comb begin
        case (r_mode)
            MODE_DOT:  loop_cont = i_ok && j_ok;
            MODE_SQD:  loop_cont = i_ok || j_ok;
            MODE_DIST: loop_cont = i_ok || j_ok;
            default:   loop_cont = 1'b0;
        endcase
    end

    assign wr_entry = '{idx: i_in_data.column_index, val: i_in_data.element_value};

    // Load acceptance: reject when full or when the column does not climb.
    always_comb begin
        wr_first  = 1'b0;
        wr_second = 1'b0;
        if (in_fire && i_in_data.operation == OP_LOAD_FIRST) begin
            wr_first = (r_first_count != CNT_W'(MAX_NZ)) &&
                       !((r_first_count != '0) && (i_in_data.column_index <= r_first_last));
        end
        if (in_fire && i_in_data.operation == OP_LOAD_SECOND) begin
            wr_second = (r_second_count != CNT_W'(MAX_NZ)) &&
                        !((r_second_count != '0) && (i_in_data.column_index <= r_second_last));
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && i_in_data.operation == OP_COMPUTE) n_state = S_READ;
            end
            S_READ: begin
                if (loop_cont)               n_state = S_CMP;
                else if (r_mode == MODE_DIST) n_state = S_SQRT;
                else                          n_state = S_DONE;
            end
            S_CMP: begin
                if (r_mode == MODE_DOT && !idx_eq) n_state = S_READ;
                else                               n_state = S_MUL;
            end
            S_MUL: n_state = S_ACC;
            S_ACC: n_state = S_READ;
            S_SQRT: begin
                if (r_sq_bit[0]) n_state = S_DONE;
            end
            S_DONE: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign sum_ext = {r_acc[ACC_W-1], r_acc} +
                     {{(ACC_W + 1 - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign sq_try  = r_sq_root + r_sq_bit;

    always_comb begin
        n_first_count  = r_first_count;
        n_second_count = r_second_count;
        n_first_last   = r_first_last;
        n_second_last  = r_second_last;
        n_err          = r_err;
        n_i            = r_i;
        n_j            = r_j;
        n_acc          = r_acc;
        n_sat          = r_sat;
        n_op_a         = r_op_a;
        n_op_b         = r_op_b;
        n_prod         = r_op_a * r_op_b;
        n_sq_v         = r_sq_v;
        n_sq_root      = r_sq_root;
        n_sq_bit       = r_sq_bit;
        n_out_data     = r_out_data;
        n_out_valid    = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (wr_first) begin
                    n_first_count = r_first_count + 1'b1;
                    n_first_last  = i_in_data.column_index;
                end
                if (wr_second) begin
                    n_second_count = r_second_count + 1'b1;
                    n_second_last  = i_in_data.column_index;
                end
                if (in_fire && (i_in_data.operation == OP_LOAD_FIRST ||
                                i_in_data.operation == OP_LOAD_SECOND) &&
                    !wr_first && !wr_second) begin
                    n_err = 1'b1;
                end
                if (in_fire && i_in_data.operation == OP_COMPUTE) begin
                    n_i   = '0;
                    n_j   = '0;
                    n_acc = '0;
                    n_sat = 1'b0;
                end
            end
            S_READ: begin
                n_sq_v    = r_acc;
                n_sq_root = '0;
                n_sq_bit  = SQ_BIT_INIT;
            end
            S_CMP: begin
                if (r_mode == MODE_DOT) begin
                    n_op_a = OPND_W'(signed'(r_rd_first.val));
                    n_op_b = OPND_W'(signed'(r_rd_second.val));
                    if (idx_lt) begin
                        n_i = r_i + 1'b1;
                    end else if (!idx_eq) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_j = r_j + 1'b1;
                    end
                end else if (i_ok && j_ok && idx_eq) begin
                    n_op_a = OPND_W'(signed'(r_rd_first.val)) -
                             OPND_W'(signed'(r_rd_second.val));
                    n_op_b = n_op_a;
                    n_i    = r_i + 1'b1;
                    n_j    = r_j + 1'b1;
                end else if (!j_ok || (i_ok && idx_lt)) begin
                    n_op_a = OPND_W'(signed'(r_rd_first.val));
                    n_op_b = n_op_a;
                    n_i    = r_i + 1'b1;
                end else begin
                    n_op_a = OPND_W'(signed'(r_rd_second.val));
                    n_op_b = n_op_a;
                    n_j    = r_j + 1'b1;
                end
            end
            S_ACC: begin
                if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
                    n_sat = 1'b1;
                    n_acc = sum_ext[ACC_W] ? ACC_MIN : ACC_MAX;
                end else begin
                    n_acc = sum_ext[ACC_W-1:0];
                end
            end
            S_SQRT: begin
                if (r_sq_v >= sq_try) begin
                    n_sq_v    = r_sq_v - sq_try;
                    n_sq_root = (r_sq_root >> 1) + r_sq_bit;
                end else begin
                    n_sq_root = r_sq_root >> 1;
                end
                n_sq_bit = r_sq_bit >> 2;
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data.result_value = (r_mode == MODE_DIST) ? r_sq_root : r_acc;
                    n_out_data.saturated    = r_sat;
                    n_out_data.load_error   = r_err;
                    n_first_count  = '0;
                    n_second_count = '0;
                    n_err          = 1'b0;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    // Buffer memories: written by loads, read at the walk pointers.
    always_ff @(posedge i_clk) begin
        if (wr_first) begin
            mem_first[r_first_count[ADDR_W-1:0]] <= wr_entry;
        end
        if (wr_second) begin
            mem_second[r_second_count[ADDR_W-1:0]] <= wr_entry;
        end
        r_rd_first  <= mem_first[r_i[ADDR_W-1:0]];
        r_rd_second <= mem_second[r_j[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_mode         <= MODE_DOT;
            r_first_count  <= '0;
            r_second_count <= '0;
            r_err          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_first_count  <= n_first_count;
            r_second_count <= n_second_count;
            r_err          <= n_err;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_last  <= n_first_last;
        r_second_last <= n_second_last;
        r_i           <= n_i;
        r_j           <= n_j;
        r_acc         <= n_acc;
        r_sat         <= n_sat;
        r_op_a        <= n_op_a;
        r_op_b        <= n_op_b;
        r_prod        <= n_prod;
        r_sq_v        <= n_sq_v;
        r_sq_root     <= n_sq_root;
        r_sq_bit      <= n_sq_bit;
        r_out_data    <= n_out_data;
    end

endmodule

// ===== hdl/svs_checker.sv =====
`timescale 1ns / 1ps
module svs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input svs_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input svs_pkg::t_out_item o_out_data
);
    import svs_pkg::*;

    logic in_fire;
    assign in_fire = i_in_valid && o_in_ready;

    // A result waiting for transfer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped before its transfer");

    // Loads and unused operations never produce a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.operation != OP_COMPUTE && !o_out_valid |=> !o_out_valid)
        else $error("result appeared after a load");

    // A compute holds off further input while it walks the buffers.
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.operation == OP_COMPUTE |=> !o_in_ready)
        else $error("input ready right after a compute transfer");

    // A new result only comes out of a compute that was in progress.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared while the core was idle");

endmodule

bind sparse_vector_similarity_core svs_checker u_svs_checker (.*);
